// ----- hw/rtl/token_lexer_stream_macros.svh -----
// Assertion macros shared by the tokenizer modules.
// Define ASSERT_OFF to compile the checks out.
`ifndef TOKEN_LEXER_STREAM_MACROS_SVH
`define TOKEN_LEXER_STREAM_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define TLEX_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tokenizer assertion failed");

// The expression must never be true at a clock edge outside reset.
`define TLEX_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tokenizer forbidden condition seen");

`else

`define TLEX_ASSERT(lbl, clk, rst, prop)
`define TLEX_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ----- hw/rtl/tlex_pkg.sv -----
package tlex_pkg;

   // Default width of the internal line counter.
   localparam int LINE_BITS_DEF = 20;

   // Width of the reported line number.
   localparam int LINE_OUT_W = 20;

   // Depth of the result queue; must be a power of two and at least two.
   localparam int OUT_DEPTH = 4;

   // Keyword buffer size and keyword count.
   localparam int KW_BUF_LEN = 5;
   localparam int NUM_KW = 15;

   // Control characters that the scanner decodes.
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   // Scanner modes.
   typedef enum logic [3:0] {
      M_IDLE    = 4'd0,
      M_IDENT   = 4'd1,
      M_NUMBER  = 4'd2,
      M_STRING  = 4'd3,
      M_ESCAPE  = 4'd4,
      M_COMMENT = 4'd5,
      M_PEQ     = 4'd6,
      M_PBANG   = 4'd7,
      M_PLT     = 4'd8,
      M_PGT     = 4'd9
   } scan_mode_type;

   // Result kinds.
   typedef enum logic [5:0] {
      K_VALUE       = 6'd0,
      K_PLUS        = 6'd1,
      K_MINUS       = 6'd2,
      K_STAR        = 6'd3,
      K_SLASH       = 6'd4,
      K_LPAREN      = 6'd5,
      K_RPAREN      = 6'd6,
      K_LBRACK      = 6'd7,
      K_RBRACK      = 6'd8,
      K_LBRACE      = 6'd9,
      K_RBRACE      = 6'd10,
      K_COMMA       = 6'd11,
      K_COLON       = 6'd12,
      K_ASSIGN      = 6'd13,
      K_EQ          = 6'd14,
      K_NE          = 6'd15,
      K_LT          = 6'd16,
      K_LE          = 6'd17,
      K_GT          = 6'd18,
      K_GE          = 6'd19,
      K_NEWLINE     = 6'd20,
      K_IDENT       = 6'd21,
      K_NUMBER      = 6'd22,
      K_STRING      = 6'd23,
      K_KW_LOOP     = 6'd24,
      K_KW_EACH     = 6'd25,
      K_KW_IN       = 6'd26,
      K_KW_STOP     = 6'd27,
      K_KW_NEXT     = 6'd28,
      K_KW_GIVE     = 6'd29,
      K_KW_IF       = 6'd30,
      K_KW_ELIF     = 6'd31,
      K_KW_ELSE     = 6'd32,
      K_KW_DEF      = 6'd33,
      K_KW_TRUE     = 6'd34,
      K_KW_FALSE    = 6'd35,
      K_KW_NULL     = 6'd36,
      K_KW_PRINT    = 6'd37,
      K_KW_END      = 6'd38,
      K_EOF         = 6'd39,
      K_ERR_BANG    = 6'd40,
      K_ERR_UNKNOWN = 6'd41,
      K_ERR_UNTERM  = 6'd42
   } tok_kind_type;

   // One result record as it sits in the result queue.
   typedef struct packed {
      tok_kind_type            kind;
      logic [7:0]              value;
      logic [LINE_OUT_W-1:0]   line;
      logic                    last;
   } tlex_res_type;

   // First five characters of the current word; entry 0 is the first.
   typedef logic [KW_BUF_LEN-1:0][7:0] kbuf_type;

   // Keyword spellings, left aligned, first character in the top byte.
   localparam logic [8*KW_BUF_LEN-1:0] KW_TEXT [NUM_KW] = '{
      {"loop", 8'h00}, {"each", 8'h00}, {"in", 24'h000000}, {"stop", 8'h00},
      {"next", 8'h00}, {"give", 8'h00}, {"if", 24'h000000}, {"elif", 8'h00},
      {"else", 8'h00}, {"def", 16'h0000}, {"true", 8'h00}, "false",
      {"null", 8'h00}, "print", {"end", 16'h0000}
   };

   localparam logic [2:0] KW_LEN [NUM_KW] = '{
      3'd4, 3'd4, 3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4,
      3'd4, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd3
   };

   // Classify a finished word: a keyword kind, or identifier when none matches.
   function automatic tok_kind_type kw_kind(input kbuf_type kbuf, input logic [2:0] len);
      tok_kind_type kind;
      logic         hit;
      kind = K_IDENT;
      for (int k = 0; k < NUM_KW; k++) begin
         hit = (KW_LEN[k] == len);
         for (int i = 0; i < KW_BUF_LEN; i++) begin
            if ((3'(i) < len) && (kbuf[i] != KW_TEXT[k][8*KW_BUF_LEN-1-8*i -: 8])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            kind = tok_kind_type'(6'(int'(K_KW_LOOP) + k));
         end
      end
      return kind;
   endfunction

endpackage

// ----- hw/rtl/token_lexer_stream.sv -----
// Streaming tokenizer for a small scripting language.
// Input channel (req_): one source byte per transfer; req_end_of_input or a
// zero byte ends the source. Result channel (rsp_): one record per transfer,
// with kind, value byte, line number and a flag on the last record that a
// byte caused. A byte causes zero, one or two records.
// A taken byte goes into the input register; its records are then written into
// the result queue, from whose head rsp_ is driven.
// Throughput: one byte per cycle while req_stall is low. The byte sits in an input
// register, the decode of the scanner state is combinational, and the records go
// into a four-entry result queue. The input register keeps its byte and req_stall
// rises while that queue holds more than two records, so the rate is set by the
// single result port: bytes that cause two records take two transfers of output.
// Reset clears the scanner to idle with line 1 and empties the queue. End of
// input returns the scanner to the same state after its end record.
// When the receiver stalls, the head record holds steady and the queue fills;
// req_stall then rises until space returns.
module token_lexer_stream #(
   parameter int LINE_BITS = tlex_pkg::LINE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_src_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [7:0]  rsp_value_byte,
   output logic [19:0] rsp_line_number,
   output logic        rsp_last_of_run
);
   import tlex_pkg::*;

   logic         stg_valid_ff, stg_valid_in;
   logic [7:0]   stg_byte_ff;
   logic         stg_end_ff;
   logic         accept;
   logic         go;
   logic         room;
   logic [1:0]   push_count;
   tlex_res_type res0, res1;
   tlex_res_type head;

   // Input register: refilled on every transfer, drained when the queue has room.
   assign go           = stg_valid_ff && room;
   assign req_stall    = stg_valid_ff && !room;
   assign accept       = req_valid && !req_stall;
   assign stg_valid_in = accept || (stg_valid_ff && !go);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_byte_ff <= req_src_byte;
         stg_end_ff  <= req_end_of_input;
      end
   end

   tlex_core #(
      .LINE_BITS(LINE_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .src_byte     (stg_byte_ff),
      .end_of_input (stg_end_ff),
      .push_count   (push_count),
      .res0         (res0),
      .res1         (res1)
   );

   tlex_out_fifo u_out (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .head       (head)
   );

   // Result port fields from the queue head.
   assign rsp_token_kind  = head.kind;
   assign rsp_value_byte  = head.value;
   assign rsp_line_number = head.line;
   assign rsp_last_of_run = head.last;

endmodule

// ----- hw/rtl/tlex_core.sv -----
`include "token_lexer_stream_macros.svh"

module tlex_core #(
   parameter int LINE_BITS = tlex_pkg::LINE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [7:0]           src_byte,
   input  logic                 end_of_input,
   output logic [1:0]           push_count,
   output tlex_pkg::tlex_res_type res0,
   output tlex_pkg::tlex_res_type res1
);
   import tlex_pkg::*;

   // Outcome of handling one byte from the idle mode.
   typedef struct packed {
      logic          hit;
      tok_kind_type  kind;
      logic [7:0]    value;
      scan_mode_type mode;
      logic          quote;
      logic          adv;
   } idle_res_type;

   scan_mode_type        mode_ff, mode_in;
   kbuf_type             kbuf_ff, kbuf_in;
   logic [2:0]           wlen_ff, wlen_in;
   logic                 point_ff, point_in;
   logic                 quote_ff, quote_in;
   logic [LINE_BITS-1:0] line_ff, line_in;

   logic                 eoi;
   idle_res_type         idle_r;
   logic                 use_idle;
   logic                 line_adv;
   logic                 prim_v, mid_v, eof_v;
   tlex_res_type         prim_r, mid_r, eof_r;
   logic [LINE_OUT_W-1:0] line_rep;
   logic [1:0]           n_res;

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   // Decode of one byte seen while no token is open.
   function automatic idle_res_type idle_eval(input logic [7:0] c);
      idle_res_type r;
      r = '0;
      r.kind = K_VALUE;
      r.mode = M_IDLE;
      case (c)
         " ", CH_TAB, CH_CR: begin
         end
         "+": begin r.hit = 1'b1; r.kind = K_PLUS;   end
         "-": begin r.hit = 1'b1; r.kind = K_MINUS;  end
         "*": begin r.hit = 1'b1; r.kind = K_STAR;   end
         "/": begin r.hit = 1'b1; r.kind = K_SLASH;  end
         "(": begin r.hit = 1'b1; r.kind = K_LPAREN; end
         ")": begin r.hit = 1'b1; r.kind = K_RPAREN; end
         "[": begin r.hit = 1'b1; r.kind = K_LBRACK; end
         "]": begin r.hit = 1'b1; r.kind = K_RBRACK; end
         "{": begin r.hit = 1'b1; r.kind = K_LBRACE; end
         "}": begin r.hit = 1'b1; r.kind = K_RBRACE; end
         ",": begin r.hit = 1'b1; r.kind = K_COMMA;  end
         ":": begin r.hit = 1'b1; r.kind = K_COLON;  end
         "#": r.mode = M_COMMENT;
         "=": r.mode = M_PEQ;
         "!": r.mode = M_PBANG;
         "<": r.mode = M_PLT;
         ">": r.mode = M_PGT;
         CH_LF: begin
            r.hit  = 1'b1;
            r.kind = K_NEWLINE;
            r.adv  = 1'b1;
         end
         "\"", "'": begin
            r.mode  = M_STRING;
            r.quote = (c == "'");
         end
         default: begin
            if (is_alpha(c) || (c == "_")) begin
               r.hit   = 1'b1;
               r.value = c;
               r.mode  = M_IDENT;
            end else if (is_digit(c)) begin
               r.hit   = 1'b1;
               r.value = c;
               r.mode  = M_NUMBER;
            end else begin
               r.hit   = 1'b1;
               r.kind  = K_ERR_UNKNOWN;
               r.value = c;
            end
         end
      endcase
      return r;
   endfunction

   // A zero byte ends the input just like the flag.
   assign eoi      = end_of_input || (src_byte == CH_NUL);
   assign idle_r   = idle_eval(src_byte);
   assign line_rep = LINE_OUT_W'(line_ff);

   // Per-mode decode: a primary record, a middle record and the end record.
   always_comb begin
      mode_in  = mode_ff;
      kbuf_in  = kbuf_ff;
      wlen_in  = wlen_ff;
      point_in = point_ff;
      quote_in = quote_ff;
      line_in  = line_ff;
      use_idle = 1'b0;
      line_adv = 1'b0;
      prim_v   = 1'b0;
      mid_v    = 1'b0;
      eof_v    = 1'b0;
      prim_r   = '{kind: K_VALUE, value: 8'h00, line: line_rep, last: 1'b0};
      mid_r    = '{kind: K_VALUE, value: 8'h00, line: line_rep, last: 1'b0};
      eof_r    = '{kind: K_EOF, value: 8'h00, line: line_rep, last: 1'b0};

      case (mode_ff)
         M_IDENT: begin
            prim_v = 1'b1;
            if (!eoi && (is_alpha(src_byte) || is_digit(src_byte) || (src_byte == "_"))) begin
               if (wlen_ff < 3'd5) begin
                  kbuf_in[wlen_ff] = src_byte;
               end
               if (wlen_ff < 3'd6) begin
                  wlen_in = wlen_ff + 3'd1;
               end
               prim_r.value = src_byte;
            end else begin
               prim_r.kind = kw_kind(kbuf_ff, wlen_ff);
               mode_in     = M_IDLE;
               use_idle    = !eoi;
            end
         end
         M_NUMBER: begin
            prim_v = 1'b1;
            if (!eoi && (is_digit(src_byte) || ((src_byte == ".") && !point_ff))) begin
               if (src_byte == ".") begin
                  point_in = 1'b1;
               end
               prim_r.value = src_byte;
            end else begin
               prim_r.kind = K_NUMBER;
               mode_in     = M_IDLE;
               use_idle    = !eoi;
            end
         end
         M_STRING: begin
            if (eoi) begin
               prim_v      = 1'b1;
               prim_r.kind = K_ERR_UNTERM;
            end else if (src_byte == (quote_ff ? 8'("'") : 8'("\""))) begin
               prim_v      = 1'b1;
               prim_r.kind = K_STRING;
               mode_in     = M_IDLE;
            end else if (src_byte == "\\") begin
               mode_in = M_ESCAPE;
            end else begin
               prim_v       = 1'b1;
               prim_r.value = src_byte;
               line_adv     = (src_byte == CH_LF);
            end
         end
         M_ESCAPE: begin
            prim_v = 1'b1;
            if (eoi) begin
               prim_r.kind = K_ERR_UNTERM;
            end else begin
               mode_in  = M_STRING;
               line_adv = (src_byte == CH_LF);
               if (src_byte == "n") begin
                  prim_r.value = CH_LF;
               end else if (src_byte == "t") begin
                  prim_r.value = CH_TAB;
               end else if ((src_byte == "\\") || (src_byte == "\"") || (src_byte == "'")) begin
                  prim_r.value = src_byte;
               end else begin
                  // Unknown escape: the backslash, then the byte itself.
                  prim_r.value = "\\";
                  mid_v        = 1'b1;
                  mid_r.value  = src_byte;
               end
            end
         end
         M_COMMENT: begin
            use_idle = !eoi && ((src_byte == CH_LF) || (src_byte == CH_CR));
         end
         M_PEQ, M_PBANG, M_PLT, M_PGT: begin
            prim_v  = 1'b1;
            mode_in = M_IDLE;
            if (!eoi && (src_byte == "=")) begin
               case (mode_ff)
                  M_PEQ:   prim_r.kind = K_EQ;
                  M_PBANG: prim_r.kind = K_NE;
                  M_PLT:   prim_r.kind = K_LE;
                  default: prim_r.kind = K_GE;
               endcase
            end else begin
               case (mode_ff)
                  M_PEQ:   prim_r.kind = K_ASSIGN;
                  M_PBANG: prim_r.kind = K_ERR_BANG;
                  M_PLT:   prim_r.kind = K_LT;
                  default: prim_r.kind = K_GT;
               endcase
               use_idle = !eoi;
            end
         end
         default: begin
            mode_in  = M_IDLE;
            use_idle = !eoi;
         end
      endcase

      // A byte that ended an open token without being part of it, or any byte in idle, is decoded afresh.
      if (use_idle) begin
         mode_in     = idle_r.mode;
         mid_v       = idle_r.hit;
         mid_r.kind  = idle_r.kind;
         mid_r.value = idle_r.value;
         line_adv    = idle_r.adv;
         if (idle_r.mode == M_STRING) begin
            quote_in = idle_r.quote;
         end
         if (idle_r.mode == M_IDENT) begin
            kbuf_in[0] = src_byte;
            wlen_in    = 3'd1;
         end
         if (idle_r.mode == M_NUMBER) begin
            point_in = 1'b0;
         end
      end

      // The line count saturates at its all-ones value.
      if (line_adv && !(&line_ff)) begin
         line_in = line_ff + LINE_BITS'(1);
      end

      // End of input: the end record, then everything back to reset values.
      if (eoi) begin
         eof_v    = 1'b1;
         mode_in  = M_IDLE;
         wlen_in  = 3'd0;
         point_in = 1'b0;
         quote_in = 1'b0;
         line_in  = LINE_BITS'(1);
      end
   end

   // Pack the records that fired into at most two slots, in order.
   always_comb begin
      n_res = 2'(prim_v) + 2'(mid_v) + 2'(eof_v);
      if (prim_v) begin
         res0 = prim_r;
      end else if (mid_v) begin
         res0 = mid_r;
      end else begin
         res0 = eof_r;
      end
      if (prim_v && mid_v) begin
         res1 = mid_r;
      end else begin
         res1 = eof_r;
      end
      res0.last  = (n_res == 2'd1);
      res1.last  = 1'b1;
      push_count = go ? n_res : 2'd0;
   end

   // Scanner control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         wlen_ff  <= 3'd0;
         point_ff <= 1'b0;
         quote_ff <= 1'b0;
         line_ff  <= LINE_BITS'(1);
      end else if (go) begin
         mode_ff  <= mode_in;
         wlen_ff  <= wlen_in;
         point_ff <= point_in;
         quote_ff <= quote_in;
         line_ff  <= line_in;
      end
   end

   // Keyword buffer; entries are read only after being written.
   always_ff @(posedge clock) begin
      if (go) begin
         kbuf_ff <= kbuf_in;
      end
   end

   `TLEX_ASSERT(a_eoi_clears, clock, reset, (go && eoi) |=> (mode_ff == M_IDLE && line_ff == LINE_BITS'(1)))
   `TLEX_ASSERT(a_eof_is_last, clock, reset, (go && eoi) |-> ((push_count == 2'd2) ? (res1.kind == K_EOF) : (res0.kind == K_EOF)))
   `TLEX_ASSERT_NEVER(a_line_zero, clock, reset, line_ff == '0)
   `TLEX_ASSERT_NEVER(a_wlen_range, clock, reset, wlen_ff > 3'd6)

endmodule

// ----- hw/rtl/tlex_out_fifo.sv -----
`include "token_lexer_stream_macros.svh"

module tlex_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_count,
   input  tlex_pkg::tlex_res_type push0,
   input  tlex_pkg::tlex_res_type push1,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tlex_pkg::tlex_res_type head
);
   import tlex_pkg::*;

   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   tlex_res_type     mem_ff [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;
   logic             pop;

   // Room means two records can be written whatever the receiver does.
   assign room      = (count_ff <= CNT_W'(OUT_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign head      = mem_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_next   = wr_ff + PTR_W'(1);

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_in    = wr_ff + PTR_W'(push_count);
      rd_in    = pop ? (rd_ff + PTR_W'(1)) : rd_ff;
      count_in = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Record storage.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next] <= push1;
      end
   end

   `TLEX_ASSERT(a_push_has_room, clock, reset, (push_count != 2'd0) |-> room)
   `TLEX_ASSERT_NEVER(a_overflow, clock, reset, count_ff > CNT_W'(OUT_DEPTH))
   `TLEX_ASSERT(a_stall_holds, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(head)))

endmodule
